// ----- sv/sbh_pkg.sv -----
// package for the segment box hit test block
// shared defaults and the closest point mode type, used by the front, back and top level
`default_nettype none
package sbh_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [1:0]
    {
        MODE_START,
        MODE_END,
        MODE_LERP
    } mode_t;

endpackage
`default_nettype wire

// ----- sv/sbh_front.sv -----
// front part: differences, dot products and classification of each segment/box beat
// depends on sbh_pkg; feeds a packed beat into sbh_queue
`default_nettype none
module sbh_front #(
    parameter int COORD_BITS = sbh_pkg::COORD_BITS_DEF,
    parameter int PACK_W     = 2 + 2 * (2 * COORD_BITS + 4) + 12 * COORD_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] start_z,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    input  wire logic signed [COORD_BITS-1:0] end_z,
    input  wire logic signed [COORD_BITS-1:0] center_x,
    input  wire logic signed [COORD_BITS-1:0] center_y,
    input  wire logic signed [COORD_BITS-1:0] center_z,
    input  wire logic        [COORD_BITS-2:0] half_width,
    input  wire logic        [COORD_BITS-2:0] height_above,
    input  wire logic        [COORD_BITS-2:0] depth_below,
    output logic                              push,
    output logic             [PACK_W-1:0]     push_data,
    input  wire logic                         full
);

    localparam int C  = COORD_BITS;
    localparam int PW = 2 * C + 4;

    logic                adv;
    logic [2:0]          vld_reg;

    logic signed [C-1:0] s1_s_reg [0:2];
    logic signed [C-1:0] s1_c_reg [0:2];
    logic signed [C:0]   s1_v_reg [0:2];
    logic signed [C:0]   s1_w_reg [0:2];
    logic [C-2:0]        s1_hw_reg, s1_ha_reg, s1_db_reg;

    logic signed [C-1:0]   s2_s_reg [0:2];
    logic signed [C-1:0]   s2_c_reg [0:2];
    logic signed [C:0]     s2_v_reg [0:2];
    logic signed [2*C+1:0] s2_wv_reg [0:2];
    logic signed [2*C+1:0] s2_vv_reg [0:2];
    logic [C-2:0]          s2_hw_reg, s2_ha_reg, s2_db_reg;

    logic signed [C-1:0] s3_s_reg [0:2];
    logic signed [C-1:0] s3_c_reg [0:2];
    logic signed [C:0]   s3_v_reg [0:2];
    logic signed [PW-1:0] s3_c1_reg, s3_c2_reg;
    logic [C-2:0]        s3_hw_reg, s3_ha_reg, s3_db_reg;

    logic signed [C-1:0] in_s [0:2];
    logic signed [C-1:0] in_e [0:2];
    logic signed [C-1:0] in_c [0:2];
    sbh_pkg::mode_t      mode;

    assign in_s[0] = start_x;
    assign in_s[1] = start_y;
    assign in_s[2] = start_z;
    assign in_e[0] = end_x;
    assign in_e[1] = end_y;
    assign in_e[2] = end_z;
    assign in_c[0] = center_x;
    assign in_c[1] = center_y;
    assign in_c[2] = center_z;

    assign adv      = !(vld_reg[2] && full);
    assign in_stall = !adv;
    assign push     = vld_reg[2] && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_s_reg[i]  <= in_s[i];
                s1_c_reg[i]  <= in_c[i];
                s1_v_reg[i]  <= $signed({in_e[i][C-1], in_e[i]}) - $signed({in_s[i][C-1], in_s[i]});
                s1_w_reg[i]  <= $signed({in_c[i][C-1], in_c[i]}) - $signed({in_s[i][C-1], in_s[i]});
                s2_s_reg[i]  <= s1_s_reg[i];
                s2_c_reg[i]  <= s1_c_reg[i];
                s2_v_reg[i]  <= s1_v_reg[i];
                s2_wv_reg[i] <= s1_w_reg[i] * s1_v_reg[i];
                s2_vv_reg[i] <= s1_v_reg[i] * s1_v_reg[i];
                s3_s_reg[i]  <= s2_s_reg[i];
                s3_c_reg[i]  <= s2_c_reg[i];
                s3_v_reg[i]  <= s2_v_reg[i];
            end
            s1_hw_reg <= half_width;
            s1_ha_reg <= height_above;
            s1_db_reg <= depth_below;
            s2_hw_reg <= s1_hw_reg;
            s2_ha_reg <= s1_ha_reg;
            s2_db_reg <= s1_db_reg;
            s3_hw_reg <= s2_hw_reg;
            s3_ha_reg <= s2_ha_reg;
            s3_db_reg <= s2_db_reg;
            s3_c1_reg <= PW'(s2_wv_reg[0]) + PW'(s2_wv_reg[1]) + PW'(s2_wv_reg[2]);
            s3_c2_reg <= PW'(s2_vv_reg[0]) + PW'(s2_vv_reg[1]) + PW'(s2_vv_reg[2]);
        end
    end

    always_comb
    begin
        if (s3_c1_reg[PW-1] || s3_c1_reg == '0)
        begin
            mode = sbh_pkg::MODE_START;
        end
        else if (s3_c1_reg >= s3_c2_reg)
        begin
            mode = sbh_pkg::MODE_END;
        end
        else
        begin
            mode = sbh_pkg::MODE_LERP;
        end
    end

    assign push_data = {2'(mode), s3_c1_reg, s3_c2_reg,
                        s3_s_reg[0], s3_s_reg[1], s3_s_reg[2],
                        s3_v_reg[0], s3_v_reg[1], s3_v_reg[2],
                        s3_c_reg[0], s3_c_reg[1], s3_c_reg[2],
                        s3_hw_reg, s3_ha_reg, s3_db_reg};

endmodule
`default_nettype wire

// ----- sv/sbh_queue.sv -----
// short queue between the front and back parts
// no package dependency; width and depth come from the top level
`default_nettype none
module sbh_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic      [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ----- sv/sbh_back.sv -----
// back part: bit-per-stage restoring divider, interpolation and box compare
// depends on sbh_pkg; takes packed beats from sbh_queue
`default_nettype none
module sbh_back #(
    parameter int COORD_BITS = sbh_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sbh_pkg::FRAC_BITS_DEF,
    parameter int PACK_W     = 2 + 2 * (2 * COORD_BITS + 4) + 12 * COORD_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              not_empty,
    input  wire logic [PACK_W-1:0] pop_data,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   hit
);

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int PW    = 2 * C + 4;
    localparam int DB_LO = 0;
    localparam int HA_LO = DB_LO + C - 1;
    localparam int HW_LO = HA_LO + C - 1;
    localparam int CZ_LO = HW_LO + C - 1;
    localparam int CY_LO = CZ_LO + C;
    localparam int CX_LO = CY_LO + C;
    localparam int VZ_LO = CX_LO + C;
    localparam int VY_LO = VZ_LO + C + 1;
    localparam int VX_LO = VY_LO + C + 1;
    localparam int SZ_LO = VX_LO + C + 1;
    localparam int SY_LO = SZ_LO + C;
    localparam int SX_LO = SY_LO + C;
    localparam int C2_LO = SX_LO + C;
    localparam int C1_LO = C2_LO + PW;
    localparam int MD_LO = C1_LO + PW;

    logic              adv;
    logic [F:0]        dvld_reg;
    logic [PACK_W-1:0] dq_reg  [0:F];
    logic [PW-1:0]     rem_reg [0:F];
    logic [F-1:0]      quo_reg [0:F];

    logic                    mvld_reg;
    sbh_pkg::mode_t          m_mode_reg;
    logic signed [C-1:0]     m_s_reg [0:2];
    logic signed [C:0]       m_v_reg [0:2];
    logic signed [C-1:0]     m_c_reg [0:2];
    logic signed [C+F+1:0]   m_prod_reg [0:2];
    logic [C-2:0]            m_hw_reg, m_ha_reg, m_db_reg;

    logic                    ovld_reg;
    logic                    hit_reg;

    logic signed [C-1:0]     q_s [0:2];
    logic signed [C:0]       q_v [0:2];
    logic signed [C-1:0]     q_c [0:2];
    logic signed [F:0]       frac;
    logic signed [C+F+1:0]   shifted [0:2];
    logic signed [C+1:0]     pnt [0:2];
    logic signed [C+2:0]     pe [0:2];
    logic signed [C+2:0]     ce [0:2];
    logic signed [C+2:0]     hwe, hae, dbe;
    logic                    hit_next;

    assign adv       = !(ovld_reg && out_stall);
    assign pop       = not_empty && adv;
    assign out_valid = ovld_reg;
    assign hit       = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvld_reg <= '0;
            mvld_reg <= 1'b0;
            ovld_reg <= 1'b0;
        end
        else if (adv)
        begin
            dvld_reg <= {dvld_reg[F-1:0], not_empty};
            mvld_reg <= dvld_reg[F];
            ovld_reg <= mvld_reg;
        end
    end

    // divider, one quotient bit per stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dq_reg[0]  <= pop_data;
            rem_reg[0] <= pop_data[C1_LO +: PW];
            quo_reg[0] <= '0;
            for (int k = 0; k < F; k++)
            begin
                dq_reg[k+1] <= dq_reg[k];
                if ({rem_reg[k][PW-2:0], 1'b0} >= dq_reg[k][C2_LO +: PW])
                begin
                    rem_reg[k+1] <= {rem_reg[k][PW-2:0], 1'b0} - dq_reg[k][C2_LO +: PW];
                    quo_reg[k+1] <= {quo_reg[k][F-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1] <= {rem_reg[k][PW-2:0], 1'b0};
                    quo_reg[k+1] <= {quo_reg[k][F-2:0], 1'b0};
                end
            end
        end
    end

    assign q_s[0] = dq_reg[F][SX_LO +: C];
    assign q_s[1] = dq_reg[F][SY_LO +: C];
    assign q_s[2] = dq_reg[F][SZ_LO +: C];
    assign q_v[0] = dq_reg[F][VX_LO +: C + 1];
    assign q_v[1] = dq_reg[F][VY_LO +: C + 1];
    assign q_v[2] = dq_reg[F][VZ_LO +: C + 1];
    assign q_c[0] = dq_reg[F][CX_LO +: C];
    assign q_c[1] = dq_reg[F][CY_LO +: C];
    assign q_c[2] = dq_reg[F][CZ_LO +: C];
    assign frac   = $signed({1'b0, quo_reg[F]});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_mode_reg <= sbh_pkg::mode_t'(dq_reg[F][MD_LO +: 2]);
            for (int i = 0; i < 3; i++)
            begin
                m_s_reg[i]    <= q_s[i];
                m_v_reg[i]    <= q_v[i];
                m_c_reg[i]    <= q_c[i];
                m_prod_reg[i] <= q_v[i] * frac;
            end
            m_hw_reg <= dq_reg[F][HW_LO +: C - 1];
            m_ha_reg <= dq_reg[F][HA_LO +: C - 1];
            m_db_reg <= dq_reg[F][DB_LO +: C - 1];
            hit_reg  <= hit_next;
        end
    end

    // closest point and inclusive box compare
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            shifted[i] = m_prod_reg[i] >>> F;
            case (m_mode_reg)
                sbh_pkg::MODE_START:
                begin
                    pnt[i] = (C+2)'(m_s_reg[i]);
                end
                sbh_pkg::MODE_END:
                begin
                    pnt[i] = (C+2)'(m_s_reg[i]) + (C+2)'(m_v_reg[i]);
                end
                sbh_pkg::MODE_LERP:
                begin
                    pnt[i] = (C+2)'(m_s_reg[i]) + shifted[i][C+1:0];
                end
                default:
                begin
                    pnt[i] = (C+2)'(m_s_reg[i]);
                end
            endcase
            pe[i] = (C+3)'(pnt[i]);
            ce[i] = (C+3)'(m_c_reg[i]);
        end
        hwe = $signed({4'b0, m_hw_reg});
        hae = $signed({4'b0, m_ha_reg});
        dbe = $signed({4'b0, m_db_reg});
        hit_next = (pe[0] <= ce[0] + hwe) && (pe[0] >= ce[0] - hwe)
                && (pe[1] <= ce[1] + hwe) && (pe[1] >= ce[1] - hwe)
                && (pe[2] <= ce[2] + hae) && (pe[2] >= ce[2] - dbe);
    end

endmodule
`default_nettype wire

// ----- sv/segment_box_hit_test.sv -----
// top level of the segment box hit test
// instantiates sbh_front, sbh_queue and sbh_back; depends on sbh_pkg
//
// Takes segment/box beats and returns one hit beat per input beat, in order,
// through three front stages (differences, dot products, sums), the queue, a
// divider load stage, one divider stage per quotient bit, the interpolation
// multiply and the box compare. The divider pipeline sets the depth; throughput
// stays at one beat per cycle without stalls. The queue holds QUEUE_DEPTH
// classified beats, so once the output stalls the front still accepts up to
// QUEUE_DEPTH + 3 more beats before it raises in_stall.
`default_nettype none
module segment_box_hit_test #(
    parameter int COORD_BITS = sbh_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sbh_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] start_z,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    input  wire logic signed [COORD_BITS-1:0] end_z,
    input  wire logic signed [COORD_BITS-1:0] center_x,
    input  wire logic signed [COORD_BITS-1:0] center_y,
    input  wire logic signed [COORD_BITS-1:0] center_z,
    input  wire logic        [COORD_BITS-2:0] half_width,
    input  wire logic        [COORD_BITS-2:0] height_above,
    input  wire logic        [COORD_BITS-2:0] depth_below,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              hit
);

    localparam int PACK_W = 2 + 2 * (2 * COORD_BITS + 4) + 12 * COORD_BITS;

    logic              push, full, pop, not_empty;
    logic [PACK_W-1:0] push_data, pop_data;

    sbh_front #(
        .COORD_BITS (COORD_BITS),
        .PACK_W     (PACK_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_x      (start_x),
        .start_y      (start_y),
        .start_z      (start_z),
        .end_x        (end_x),
        .end_y        (end_y),
        .end_z        (end_z),
        .center_x     (center_x),
        .center_y     (center_y),
        .center_z     (center_z),
        .half_width   (half_width),
        .height_above (height_above),
        .depth_below  (depth_below),
        .push         (push),
        .push_data    (push_data),
        .full         (full)
    );

    sbh_queue #(
        .WIDTH (PACK_W),
        .DEPTH (sbh_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_data  (pop_data)
    );

    sbh_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .PACK_W     (PACK_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit)
    );

endmodule
`default_nettype wire

// ----- bench/segment_box_hit_test_tb.sv -----
// testbench for segment_box_hit_test: directed table then random segment/box beats
// predicts hit by closest point math or table value; depends on sbh_pkg and the block
`default_nettype none
module segment_box_hit_test_tb;

    localparam int CB = sbh_pkg::COORD_BITS_DEF;
    localparam int FB = sbh_pkg::FRAC_BITS_DEF;
    localparam int NUM_RANDOM = 1240;

    typedef struct {
        logic signed [CB-1:0] sx, sy, sz, ex, ey, ez, cx, cy, cz;
        logic [CB-2:0] hw, ha, db;
    } pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [CB-1:0] start_x = '0, start_y = '0, start_z = '0;
    logic signed [CB-1:0] end_x = '0, end_y = '0, end_z = '0;
    logic signed [CB-1:0] center_x = '0, center_y = '0, center_z = '0;
    logic [CB-2:0] half_width = '0, height_above = '0, depth_below = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit;

    bit expected_hits[$];
    int errors = 0;
    int beats_in = 0;
    int beats_out = 0;
    int hits_seen = 0;
    bit quiet = 1'b0;

    segment_box_hit_test i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .start_x(start_x), .start_y(start_y), .start_z(start_z),
        .end_x(end_x), .end_y(end_y), .end_z(end_z),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .half_width(half_width), .height_above(height_above), .depth_below(depth_below),
        .out_valid(out_valid), .out_stall(out_stall), .hit(hit)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAIL segment_box_hit_test");
        $finish;
    end

    function automatic bit closest_point_in_box(pair_t t);
        longint s[3], e[3], c[3], v[3], p[3];
        longint c1, c2, f, hw, ha, db;
        logic [127:0] num;
        s[0] = t.sx; s[1] = t.sy; s[2] = t.sz;
        e[0] = t.ex; e[1] = t.ey; e[2] = t.ez;
        c[0] = t.cx; c[1] = t.cy; c[2] = t.cz;
        hw = longint'(t.hw);
        ha = longint'(t.ha);
        db = longint'(t.db);
        c1 = 0;
        c2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            v[i] = e[i] - s[i];
            c1 += (c[i] - s[i]) * v[i];
            c2 += v[i] * v[i];
        end
        if (c1 <= 0)
            p = s;
        else if (c1 >= c2)
            p = e;
        else
        begin
            num = {64'd0, c1} << FB;
            f = longint'(num / {64'd0, c2});
            for (int i = 0; i < 3; i++)
                p[i] = s[i] + ((v[i] * f) >>> FB);
        end
        return p[0] <= c[0] + hw && p[0] >= c[0] - hw
            && p[1] <= c[1] + hw && p[1] >= c[1] - hw
            && p[2] <= c[2] + ha && p[2] >= c[2] - db;
    endfunction

    function automatic pair_t mk(longint sx, longint sy, longint sz, longint ex, longint ey,
                                 longint ez, longint cx, longint cy, longint cz,
                                 longint hw, longint ha, longint db);
        pair_t t;
        t.sx = CB'(sx); t.sy = CB'(sy); t.sz = CB'(sz);
        t.ex = CB'(ex); t.ey = CB'(ey); t.ez = CB'(ez);
        t.cx = CB'(cx); t.cy = CB'(cy); t.cz = CB'(cz);
        t.hw = (CB-1)'(hw); t.ha = (CB-1)'(ha); t.db = (CB-1)'(db);
        return t;
    endfunction

    // valid stays high when the next beat follows without a gap
    task automatic send_pair(pair_t t, int known);
        start_x <= t.sx; start_y <= t.sy; start_z <= t.sz;
        end_x <= t.ex; end_y <= t.ey; end_z <= t.ez;
        center_x <= t.cx; center_y <= t.cy; center_z <= t.cz;
        half_width <= t.hw; height_above <= t.ha; depth_below <= t.db;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        expected_hits.push_back(known < 0 ? closest_point_in_box(t) : bit'(known));
        beats_in++;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
    endtask

    function automatic pair_t random_pair();
        pair_t t;
        int span;
        if ($urandom_range(0, 4) == 0)
        begin
            t.sx = CB'($urandom); t.sy = CB'($urandom); t.sz = CB'($urandom);
            t.ex = CB'($urandom); t.ey = CB'($urandom); t.ez = CB'($urandom);
            t.cx = CB'($urandom); t.cy = CB'($urandom); t.cz = CB'($urandom);
            t.hw = (CB-1)'($urandom); t.ha = (CB-1)'($urandom); t.db = (CB-1)'($urandom);
        end
        else
        begin
            // segment passing near a box so all three clamp modes and both outcomes occur
            span = 1 << $urandom_range(4, 20);
            t.cx = CB'($urandom_range(0, 2 * span) - span);
            t.cy = CB'($urandom_range(0, 2 * span) - span);
            t.cz = CB'($urandom_range(0, 2 * span) - span);
            t.sx = CB'(t.cx + $urandom_range(0, 2 * span) - span);
            t.sy = CB'(t.cy + $urandom_range(0, 2 * span) - span);
            t.sz = CB'(t.cz + $urandom_range(0, 2 * span) - span);
            t.ex = CB'(t.cx + $urandom_range(0, 2 * span) - span);
            t.ey = CB'(t.cy + $urandom_range(0, 2 * span) - span);
            t.ez = CB'(t.cz + $urandom_range(0, 2 * span) - span);
            t.hw = (CB-1)'($urandom_range(0, span / 2));
            t.ha = (CB-1)'($urandom_range(0, span / 2));
            t.db = (CB-1)'($urandom_range(0, span / 2));
        end
        return t;
    endfunction

    always @(negedge clk)
    begin : stall_gen
        int left;
        if (quiet)
            out_stall <= 1'b0;
        else if (left > 0)
            left--;
        else if ($urandom_range(0, 3) == 0)
        begin
            out_stall <= ~out_stall;
            left = $urandom_range(0, 10);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            beats_out++;
            if (expected_hits.size() == 0)
            begin
                $error("hit beat with nothing expected: actual %0b", hit);
                errors++;
            end
            else
            begin
                bit want;
                want = expected_hits.pop_front();
                hits_seen += want;
                if (hit !== want)
                begin
                    $error("hit: expected %0b actual %0b", want, hit);
                    errors++;
                end
            end
        end
    end

    pair_t table_rows[$];
    int table_known[$];

    initial
    begin : stimulus
        int waited;
        table_rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        table_known.push_back(1);
        table_rows.push_back(mk(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                                -8388608, -8388608, -8388608, 0, 0, 0));
        table_known.push_back(0);
        table_rows.push_back(mk(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
                                -8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
        table_known.push_back(1);
        table_rows.push_back(mk(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                                0, 0, 0, 8388607, 8388607, 8388607));
        table_known.push_back(1);
        table_rows.push_back(mk(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                                0, 0, 0, 0, 0, 0));
        table_known.push_back(-1);
        table_rows.push_back(mk(8388607, -8388608, 8388607, -8388608, 8388607, -8388608,
                                5, -7, 3, 300, 300, 300));
        table_known.push_back(-1);
        table_rows.push_back(mk(0, 0, 0, 1000, 0, 0, -500, 0, 0, 499, 10, 10));
        table_known.push_back(-1);
        table_rows.push_back(mk(0, 0, 0, 1000, 0, 0, -500, 0, 0, 500, 10, 10));
        table_known.push_back(-1);
        table_rows.push_back(mk(0, 0, 0, 1000, 0, 0, 1600, 0, 0, 600, 0, 0));
        table_known.push_back(-1);
        table_rows.push_back(mk(0, 0, 0, 1000, 0, 0, 1600, 0, 0, 599, 0, 0));
        table_known.push_back(-1);
        table_rows.push_back(mk(-300, 100, 0, 700, -900, 50, 200, -400, 40, 0, 0, 0));
        table_known.push_back(-1);
        table_rows.push_back(mk(0, 0, 0, 0, 0, 1000, 0, 0, 600, 5, 0, 100));
        table_known.push_back(-1);
        table_rows.push_back(mk(0, 0, 0, 0, 0, -1000, 0, 0, -600, 5, 100, 0));
        table_known.push_back(-1);
        table_rows.push_back(mk(3, 7, -11, 3, 7, -11, 3, 7, -11, 0, 0, 0));
        table_known.push_back(1);
        table_rows.push_back(mk(1, 1, 1, 4, 9, 2, 2, 5, 1, 1, 1, 1));
        table_known.push_back(-1);

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (table_rows[i])
            send_pair(table_rows[i], table_known[i]);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n == NUM_RANDOM / 2)
            begin
                in_valid <= 1'b0;
                while (expected_hits.size() != 0) @(negedge clk);
            end
            if (n == NUM_RANDOM - 200)
                quiet = 1'b1;
            send_pair(random_pair(), -1);
        end
        in_valid <= 1'b0;

        waited = 0;
        while (expected_hits.size() != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (FB + 20) @(negedge clk);
        if (expected_hits.size() != 0)
        begin
            $error("hit beats still expected at end: %0d", expected_hits.size());
            errors++;
        end

        $display("sent %0d segment/box beats (directed extremes, clamps, degenerate, random)",
                 beats_in);
        $display("received %0d hit beats, %0d of them hits, %0d mismatches",
                 beats_out, hits_seen, errors);
        if (errors == 0)
            $display("PASS segment_box_hit_test");
        else
            $display("FAIL segment_box_hit_test");
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
sv/sbh_pkg.sv
sv/sbh_front.sv
sv/sbh_queue.sv
sv/sbh_back.sv
sv/segment_box_hit_test.sv
bench/segment_box_hit_test_tb.sv
